@@ rtl/aba_pkg.sv @@
package aba_pkg;

  // Field widths of the command and result transactions.
  localparam int OP_W       = 1;
  localparam int KIND_W     = 2;
  localparam int SIZE_W     = 10;
  localparam int INDEX_W    = 7;
  localparam int STATUS_W   = 3;
  localparam int OFFSET_W   = 12;
  localparam int BUMP_W     = 13;
  localparam int LIVE_W     = 8;
  localparam int BYTES_W    = 13;

  // Configuration register widths and port format.
  localparam int POOL_W     = 13;
  localparam int ALIGN_W    = 7;
  localparam int GAP_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POOL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GAP   = CFG_IDX_W'(2);

  localparam logic [POOL_W-1:0]  POOL_RESET  = POOL_W'(4096);
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(8);
  localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(0);

  // Default sizing of the top level.
  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int POOL_LIMIT_DEF    = 4096;
  localparam int MAX_REQUEST_DEF   = 512;

  localparam logic             OP_ALLOC    = 1'b0;
  localparam logic             OP_DELETE   = 1'b1;
  localparam logic [KIND_W-1:0] KIND_STRING = KIND_W'(0);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_BADINDEX = 3'd3,
    ST_DEAD     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_MOD,
    S_ALLOC_BASE,
    S_ALLOC_CHK,
    S_DEL_CHK,
    S_WALK_RD,
    S_WALK_CHK
  } aba_state_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KIND_W-1:0]  item_kind;
    logic [SIZE_W-1:0]  req_bytes;
    logic [INDEX_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] alloc_offset;
    logic [INDEX_W-1:0]  alloc_index;
    logic [BUMP_W-1:0]   bump_after;
    logic [LIVE_W-1:0]   live_entries;
    logic [BYTES_W-1:0]  live_bytes;
  } out_t;

endpackage

@@ rtl/aba_align_rem.sv @@
module aba_align_rem import aba_pkg::*; #(
  parameter int DW = 13,
  parameter int RW = ALIGN_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   sh_r;
  logic [RW-1:0]   rem_r;
  logic [RW:0]     trial;
  logic [RW:0]     trial_sub;

  // Restoring remainder, one dividend bit per cycle from the top down.
  assign trial     = {rem_r, sh_r[DW-1]};
  assign trial_sub = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= trial_sub[RW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("remainder unit restarted while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("remainder unit did not begin");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("remainder done while still iterating");
  a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r) else $error("remainder unit stopped without done");
`endif

endmodule

@@ rtl/aligned_bump_allocator_unit.sv @@
// Bump-pointer arena allocator with an entry table. A command is taken when start is high
// and busy is low; each command gives exactly one result, shown on out_result for a single
// cycle with out_valid high, and the receiver must take it then, as it cannot hold results
// off. Configuration writes are taken at any time but must only be issued while the block
// is idle. A refused allocate (table full or bad size) and a delete with a bad index answer
// in the cycle after acceptance. An allocate with a nonzero alignment first waits on the
// bit-serial remainder unit, which works through one bit of the bump pointer per cycle;
// alignment zero skips it. A delete of an entry that is already dead answers after the
// table read. Any other delete marks the entry dead and then pops each dead entry off the
// tail, as the walk reads the entry memory one entry at a time.
module aligned_bump_allocator_unit import aba_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int POOL_LIMIT    = POOL_LIMIT_DEF,
  parameter int MAX_REQUEST   = MAX_REQUEST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_item,
  output logic                  out_valid,
  output out_t                  out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int PW   = $clog2(POOL_LIMIT + 1);
  localparam int OW   = $clog2(POOL_LIMIT);
  localparam int XMAX = POOL_LIMIT + (1 << ALIGN_W) + (1 << GAP_W) + (1 << SIZE_W);
  localparam int XW   = $clog2(XMAX + 1);
  localparam int CMPW = (XW > POOL_W) ? XW : POOL_W;
  localparam int SZW0 = $clog2(MAX_REQUEST + 1);
  localparam int SZCW = (SZW0 > SIZE_W) ? SZW0 : SIZE_W;
  localparam int IXW  = (CW > INDEX_W) ? CW : INDEX_W;

  typedef struct packed {
    logic              dead;
    logic [SIZE_W-1:0] size;
    logic [OW-1:0]     off;
  } ent_t;

  ent_t mem [TABLE_ENTRIES];
  ent_t mem_rdata_r;
  ent_t mem_wdata;
  logic mem_we;
  logic mem_re;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;

  aba_state_t state_r, state_nxt;
  logic [CW-1:0]      top_r, top_nxt;
  logic [PW-1:0]      bump_r, bump_nxt;
  logic [CW-1:0]      live_cnt_r, live_cnt_nxt;
  logic [PW-1:0]      live_bytes_r, live_bytes_nxt;
  in_t                req_r, req_nxt;
  logic [XW-1:0]      base_r, base_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic [POOL_W-1:0]  pool_r;
  logic [ALIGN_W-1:0] align_r;
  logic [GAP_W-1:0]   gap_r;

  logic               rem_start;
  logic               rem_done;
  logic [ALIGN_W-1:0] rem_val;

  status_t            res_status;
  logic [XW-1:0]      res_offset;
  logic [CW-1:0]      res_index;
  logic [ALIGN_W-1:0] pad;
  logic [XW-1:0]      end_w;
  logic [XW-1:0]      tail_end;
  logic               accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_result = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r  <= POOL_RESET;
      align_r <= ALIGN_RESET;
      gap_r   <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POOL:  pool_r  <= cfg_data[POOL_W-1:0];
        CFG_ALIGN: align_r <= cfg_data[ALIGN_W-1:0];
        CFG_GAP:   gap_r   <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aba_align_rem #(
    .DW (PW),
    .RW (ALIGN_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (bump_r),
    .divisor  (align_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Entry table: one write and one read port, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign pad      = ((align_r == '0) || (rem_val == '0)) ? '0 : (align_r - rem_val);
  assign end_w    = base_r + XW'(req_r.req_bytes);
  assign tail_end = XW'(mem_rdata_r.off) + XW'(mem_rdata_r.size);

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    bump_nxt       = bump_r;
    live_cnt_nxt   = live_cnt_r;
    live_bytes_nxt = live_bytes_r;
    req_nxt        = req_r;
    base_nxt       = base_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    res_status     = ST_OK;
    res_offset     = '0;
    res_index      = '0;
    rem_start      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;
    mem_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_item;
          if (in_item.op == OP_ALLOC) begin
            if (top_r >= CW'(TABLE_ENTRIES)) begin
              res_status    = ST_FULL;
              out_valid_nxt = 1'b1;
            end else if ((in_item.req_bytes == '0) ||
                         (SZCW'(in_item.req_bytes) > SZCW'(MAX_REQUEST))) begin
              res_status    = ST_NOSPACE;
              out_valid_nxt = 1'b1;
            end else if (align_r == '0) begin
              state_nxt = S_ALLOC_BASE;
            end else begin
              rem_start = 1'b1;
              state_nxt = S_ALLOC_MOD;
            end
          end else begin
            if (IXW'(in_item.entry_index) >= IXW'(top_r)) begin
              res_status    = ST_BADINDEX;
              out_valid_nxt = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = IW'(in_item.entry_index);
              state_nxt = S_DEL_CHK;
            end
          end
        end
      end

      S_ALLOC_MOD: begin
        if (rem_done) begin
          state_nxt = S_ALLOC_BASE;
        end
      end

      S_ALLOC_BASE: begin
        base_nxt = XW'(bump_r) + XW'(pad);
        if (req_r.item_kind == KIND_STRING) begin
          base_nxt = XW'(bump_r) + XW'(pad) + XW'(gap_r);
        end
        state_nxt = S_ALLOC_CHK;
      end

      S_ALLOC_CHK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if ((CMPW'(end_w) > CMPW'(pool_r)) || (CMPW'(end_w) > CMPW'(POOL_LIMIT))) begin
          res_status = ST_NOSPACE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = IW'(top_r);
          mem_wdata.dead = 1'b0;
          mem_wdata.size = req_r.req_bytes;
          mem_wdata.off  = OW'(base_r);
          res_offset     = base_r;
          res_index      = top_r;
          top_nxt        = top_r + CW'(1);
          live_cnt_nxt   = live_cnt_r + CW'(1);
          live_bytes_nxt = live_bytes_r + PW'(req_r.req_bytes);
          bump_nxt       = PW'(end_w);
        end
      end

      S_DEL_CHK: begin
        if (mem_rdata_r.dead) begin
          res_status    = ST_DEAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = IW'(req_r.entry_index);
          mem_wdata      = mem_rdata_r;
          mem_wdata.dead = 1'b1;
          live_cnt_nxt   = live_cnt_r - CW'(1);
          live_bytes_nxt = live_bytes_r - PW'(mem_rdata_r.size);
          state_nxt      = S_WALK_RD;
        end
      end

      // The mark written in the previous state is visible to this read.
      S_WALK_RD: begin
        if (top_r == '0) begin
          bump_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IW'(top_r - CW'(1));
          state_nxt = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        if (mem_rdata_r.dead) begin
          top_nxt   = top_r - CW'(1);
          state_nxt = S_WALK_RD;
        end else begin
          bump_nxt      = PW'(tail_end);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      out_nxt.status       = res_status;
      out_nxt.alloc_offset = OFFSET_W'(res_offset);
      out_nxt.alloc_index  = INDEX_W'(res_index);
      out_nxt.bump_after   = BUMP_W'(bump_nxt);
      out_nxt.live_entries = LIVE_W'(live_cnt_nxt);
      out_nxt.live_bytes   = BYTES_W'(live_bytes_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      top_r        <= '0;
      bump_r       <= '0;
      live_cnt_r   <= '0;
      live_bytes_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      bump_r       <= bump_nxt;
      live_cnt_r   <= live_cnt_nxt;
      live_bytes_r <= live_bytes_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    base_r <= base_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid)) else $error("accepted transaction went nowhere");
  a_live_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r <= top_r) else $error("live count exceeds table top");
  a_bump_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= PW'(POOL_LIMIT)) else $error("bump pointer beyond pool limit");
  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re) else $error("entry table read and written together");
`endif

endmodule
